>>> sv/token_bucket_packet_shaper_assert.svh
// assertion macros for the token bucket packet shaper
`ifndef TOKEN_BUCKET_PACKET_SHAPER_ASSERT_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TBPS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tbps assertion failed");

// next-cycle implication, checked outside reset
`define TBPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tbps assertion failed");

`endif

>>> sv/tbps_pkg.sv
package tbps_pkg;

    // field widths
    localparam int SIZE_W = 16;
    localparam int ID_W   = 16;
    localparam int TOK_W  = 16;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    // sizing
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

    // reset values of the registers
    localparam logic [CFG_W-1:0] CAPACITY_RST = 16'd50;
    localparam logic [CFG_W-1:0] AMOUNT_RST   = 16'd5;
    localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd1000;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [IDX_W-1:0] REG_AMOUNT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_PERIOD   = 2'd2;

    // operation codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_ENQUEUE = 1'b1;

    // result kinds
    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // classified command from front to back
    typedef struct packed {
        logic              op;
        logic              too_large;
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   id;
    } cmd_t;

    // configuration seen by the back part
    typedef struct packed {
        logic [CFG_W-1:0] capacity;
        logic [CFG_W-1:0] amount;
        logic [CFG_W-1:0] period;
        logic             reload;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        logic [ID_W-1:0]   sent_id;
        logic [SIZE_W-1:0] sent_size;
        logic [TIME_W-1:0] send_time;
        logic              last;
    } result_t;

endpackage

>>> sv/token_bucket_packet_shaper.sv
// token bucket shaper in front of a descriptor queue
// an accepted item waits in a two-entry command queue until the sequencer is idle; the
// reply word is held until ST_HEAD_CHK knows whether a release follows, and waits there
// while the output is stalled; each release passes through ST_HEAD_RD and ST_HEAD_CHK
// for the registered read of the descriptor memory, and no new item is taken meanwhile
// reset: aresetn is synchronous, active low; queue empty, 5 tokens, registers 50 / 5 / 1000
module token_bucket_packet_shaper #(
    parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [tbps_pkg::SIZE_W-1:0]  s_packet_size,
    input  logic [tbps_pkg::ID_W-1:0]    s_packet_id,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kind,
    output logic [1:0]                   m_status,
    output logic [tbps_pkg::ID_W-1:0]    m_sent_id,
    output logic [tbps_pkg::SIZE_W-1:0]  m_sent_size,
    output logic [tbps_pkg::TIME_W-1:0]  m_send_time,
    output logic                         m_last,
    input  logic                         cfg_wr_en,
    input  logic [tbps_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tbps_pkg::CFG_W-1:0]   cfg_wdata
);
    import tbps_pkg::*;

    logic [CFG_W-1:0] capacity_reg;
    logic [CFG_W-1:0] amount_reg;
    logic [CFG_W-1:0] period_reg;
    cfg_t             cfg;
    cmd_t             cmd;
    logic             cmd_valid;
    logic             cmd_ready;
    result_t          result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RST;
            amount_reg   <= AMOUNT_RST;
            period_reg   <= PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CAPACITY: capacity_reg <= cfg_wdata;
                REG_AMOUNT:   amount_reg   <= cfg_wdata;
                REG_PERIOD:   period_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.capacity = capacity_reg;
        cfg.amount   = (cfg_wr_en && cfg_index == REG_AMOUNT) ? cfg_wdata : amount_reg;
        cfg.period   = period_reg;
        cfg.reload   = cfg_wr_en && (cfg_index == REG_AMOUNT);
    end

    tbps_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_packet_size (s_packet_size),
        .s_packet_id   (s_packet_id),
        .capacity      (capacity_reg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    tbps_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg       (cfg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result)
    );

    // result word onto the ports
    assign m_kind      = result.kind;
    assign m_status    = result.status;
    assign m_sent_id   = result.sent_id;
    assign m_sent_size = result.sent_size;
    assign m_send_time = result.send_time;
    assign m_last      = result.last;

endmodule

>>> sv/tbps_ram.sv
module tbps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/tbps_front.sv
module tbps_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [tbps_pkg::SIZE_W-1:0]  s_packet_size,
    input  logic [tbps_pkg::ID_W-1:0]    s_packet_id,
    input  logic [tbps_pkg::CFG_W-1:0]   capacity,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output tbps_pkg::cmd_t               cmd
);
    import tbps_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    cmd_t       in_cmd;

    // classify the incoming word
    always_comb begin
        in_cmd.op        = s_operation;
        in_cmd.too_large = (s_packet_size > capacity);
        in_cmd.size      = s_packet_size;
        in_cmd.id        = s_packet_id;
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // two-entry command queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // command payload
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> sv/tbps_back.sv
module tbps_back #(
    parameter int QUEUE_DEPTH = tbps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  tbps_pkg::cmd_t    cmd,
    input  tbps_pkg::cfg_t    cfg,
    output logic              m_valid,
    input  logic              m_ready,
    output tbps_pkg::result_t result
);
    import tbps_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DESC_W = SIZE_W + ID_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [RES_CNT_W-1:0] RES_LIMIT = RES_CNT_W'(MAX_RESULTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_CHK
    } state_t;

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TOK_W-1:0]      tokens_reg, tokens_next;
    logic [CFG_W-1:0]      period_cnt_reg, period_cnt_next;
    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic [RES_CNT_W-1:0]  n_reg, n_next;
    logic                  have_pend_reg, have_pend_next;
    result_t               pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    result_t               result_reg, result_next;

    logic                  ram_we;
    logic [DESC_W-1:0]     ram_rd_data;
    logic [SIZE_W-1:0]     head_size;
    logic [ID_W-1:0]       head_id;
    logic                  out_free;
    logic                  fits;
    logic [CFG_W-1:0]      period_inc;
    logic [TOK_W:0]        refill_sum;
    logic [1:0]            enq_status;

    // descriptor store: size over id
    tbps_ram #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_desc_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (tail_reg),
        .wr_data ({cmd.size, cmd.id}),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    assign head_size = ram_rd_data[DESC_W-1:ID_W];
    assign head_id   = ram_rd_data[ID_W-1:0];
    assign m_valid   = m_valid_reg;
    assign result    = result_reg;

    // refill and enqueue arithmetic
    always_comb begin
        period_inc = period_cnt_reg + 1'b1;
        refill_sum = {1'b0, tokens_reg} + {1'b0, cfg.amount};
        out_free   = !m_valid_reg || m_ready;
        fits       = (count_reg != '0) && (head_size <= tokens_reg) && (n_reg < RES_LIMIT);
        if (cmd.too_large) begin
            enq_status = STATUS_TOO_LARGE;
        end else if (count_reg == CNT_FULL) begin
            enq_status = STATUS_FULL;
        end else begin
            enq_status = STATUS_OK;
        end
    end

    // sequencer next state
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        tokens_next     = tokens_reg;
        period_cnt_next = period_cnt_reg;
        elapsed_next    = elapsed_reg;
        n_next          = n_reg;
        have_pend_next  = have_pend_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        result_next     = result_reg;
        ram_we          = 1'b0;
        cmd_ready       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    state_next = ST_HEAD_RD;
                    if (cmd.op == OP_TICK) begin
                        // advance time, refill once per period
                        n_next         = '0;
                        have_pend_next = 1'b0;
                        elapsed_next   = elapsed_reg + 1'b1;
                        if (period_inc >= cfg.period) begin
                            period_cnt_next = '0;
                            tokens_next = (refill_sum > {1'b0, cfg.capacity}) ?
                                          cfg.capacity : refill_sum[TOK_W-1:0];
                        end else begin
                            period_cnt_next = period_inc;
                        end
                    end else begin
                        // queue the descriptor if it is accepted and hold the reply
                        if (enq_status == STATUS_OK) begin
                            ram_we     = 1'b1;
                            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        n_next              = RES_CNT_W'(1);
                        have_pend_next      = 1'b1;
                        pend_next.kind      = KIND_REPLY;
                        pend_next.status    = enq_status;
                        pend_next.sent_id   = cmd.id;
                        pend_next.sent_size = '0;
                        pend_next.send_time = '0;
                        pend_next.last      = 1'b0;
                    end
                end
            end
            ST_HEAD_RD: begin
                state_next = ST_HEAD_CHK;
            end
            ST_HEAD_CHK: begin
                // the held word goes out once we know if another follows
                if (!have_pend_reg || out_free) begin
                    if (have_pend_reg) begin
                        m_valid_next     = 1'b1;
                        result_next      = pend_reg;
                        result_next.last = !fits;
                    end
                    if (fits) begin
                        have_pend_next      = 1'b1;
                        pend_next.kind      = KIND_RELEASE;
                        pend_next.status    = STATUS_OK;
                        pend_next.sent_id   = head_id;
                        pend_next.sent_size = head_size;
                        pend_next.send_time = elapsed_reg;
                        pend_next.last      = 1'b0;
                        tokens_next         = tokens_reg - head_size;
                        head_next           = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                        count_next          = count_reg - 1'b1;
                        n_next              = n_reg + 1'b1;
                        state_next          = ST_HEAD_RD;
                    end else begin
                        have_pend_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // writing the refill amount reloads the bucket
        if (cfg.reload) begin
            tokens_next = cfg.amount;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            tokens_reg     <= AMOUNT_RST;
            period_cnt_reg <= '0;
            elapsed_reg    <= '0;
            n_reg          <= '0;
            have_pend_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            tokens_reg     <= tokens_next;
            period_cnt_reg <= period_cnt_next;
            elapsed_reg    <= elapsed_next;
            n_reg          <= n_next;
            have_pend_reg  <= have_pend_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

endmodule

>>> sv/tbps_checker.sv
`include "token_bucket_packet_shaper_assert.svh"

module tbps_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_kind,
    input logic [1:0]                   m_status,
    input logic [tbps_pkg::ID_W-1:0]    m_sent_id,
    input logic [tbps_pkg::SIZE_W-1:0]  m_sent_size,
    input logic [tbps_pkg::TIME_W-1:0]  m_send_time,
    input logic                         m_last
);
    import tbps_pkg::*;

    // a stalled result word holds
    `TBPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_sent_id) && $stable(m_last))

    // releases always carry the accepted status
    `TBPS_ASSERT_NOW(a_release_status, aclk, aresetn, m_valid && (m_kind == KIND_RELEASE), m_status == STATUS_OK)

    // replies carry no size and no time
    `TBPS_ASSERT_NOW(a_reply_fields, aclk, aresetn, m_valid && (m_kind == KIND_REPLY), (m_sent_size == '0) && (m_send_time == '0))

    // only defined status codes appear
    `TBPS_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid, (m_status == STATUS_OK) || (m_status == STATUS_TOO_LARGE) || (m_status == STATUS_FULL))

endmodule

bind token_bucket_packet_shaper tbps_checker u_tbps_checker (.*);
